// ===== design/skf_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// skf_pkg
// Types and constants shared by the scalar Kalman filter controller,
// datapath and top level.
// ----------------------------------------------------------------------------
package skf_pkg;

    localparam int DATA_W     = 32;
    localparam int GAIN_W     = 16;
    localparam int MUL_B_W    = GAIN_W + 1;
    localparam int PROD_W     = DATA_W + MUL_B_W;
    localparam int DIV_CNT_W  = $clog2(GAIN_W);
    localparam int CFG_IDX_W  = 4;

    localparam logic [GAIN_W-1:0] GAIN_MAX = '1;
    localparam logic [MUL_B_W-1:0] GAIN_ONE = MUL_B_W'(1) << GAIN_W;

    localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE      = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_MEASUREMENT_NOISE  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_ESTIMATE   = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_COVARIANCE = CFG_IDX_W'(3);

    typedef struct packed {
        logic signed [DATA_W-1:0] measurement;
        logic                     last_sample;
    } skf_in_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] filtered_value;
        logic [GAIN_W-1:0]        gain;
        logic                     last_result;
    } skf_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_GAIN,
        ST_MULX,
        ST_MULP,
        ST_FINISH
    } skf_state_t;

    typedef struct packed {
        logic load;
        logic prep;
        logic div_step;
        logic set_gain;
        logic mul_x;
        logic mul_p;
        logic commit;
    } skf_cmd_t;

    typedef struct packed {
        logic div_last;
    } skf_status_t;

endpackage
`default_nettype wire

// ===== design/scalar_kalman_filter_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// scalar_kalman_filter_unit
// One-dimensional Kalman filter over a stream of Q16.16 measurements.
// ----------------------------------------------------------------------------
// Usage:
//   in channel:  in_valid / in_stall / in_data, one measurement per transfer.
//   out channel: out_valid / out_stall / out_data, one result per measurement
//                (new estimate, Q0.16 gain, copy of last_sample).
//   cfg channel: cfg_valid / cfg_ready / cfg_index / cfg_data; cfg_ready is
//                always high. Index 0 q, 1 r, 2 initial estimate (also loads
//                the estimate), 3 initial covariance (also loads covariance).
//                Write only while the filter is idle.
//   Timing: one item at a time. A result is written to the output register at
//   the end of a step and the next item can be taken in the cycle after that.
//   The step length comes mostly from the 16-step restoring gain divider plus
//   the two passes through the shared 32x17 multiplier.
//   A stalled result waits in the output register; the next item is still
//   accepted and computed, and it holds at the end until the register frees.
//   Reset clears q, r, the estimate, the covariance and all control state.
// ----------------------------------------------------------------------------
module scalar_kalman_filter_unit (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [skf_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [skf_pkg::DATA_W-1:0]          cfg_data,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire skf_pkg::skf_in_t                    in_data,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output skf_pkg::skf_out_t                        out_data
);

    skf_pkg::skf_cmd_t    cmd;
    skf_pkg::skf_status_t status;
    logic                 cfg_we;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    skf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    skf_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .cmd       (cmd),
        .status    (status),
        .out_data  (out_data)
    );

`ifndef SYNTHESIS
    // an input transfer always starts a busy step
    a_busy_after_accept: assert property (
        @(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall
    ) else $error("filter took a second item right after a transfer");

    // a new result only appears at the end of a step
    a_result_from_busy: assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall)
    ) else $error("result appeared without a step in progress");
`endif

endmodule
`default_nettype wire

// ===== design/skf_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// skf_ctrl
// Sequencer for one filter step: input transfer, divider iterations,
// the two multiplications and the hand-off to the output register.
// ----------------------------------------------------------------------------
module skf_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    output logic                    out_valid,
    input  wire logic               out_stall,
    input  wire skf_pkg::skf_status_t status,
    output skf_pkg::skf_cmd_t       cmd
);

    skf_pkg::skf_state_t state_reg;
    skf_pkg::skf_state_t state_next;
    logic                out_valid_reg;
    logic                out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= skf_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            skf_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = skf_pkg::ST_PREP;
                end
            end
            skf_pkg::ST_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = skf_pkg::ST_DIV;
            end
            skf_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = skf_pkg::ST_GAIN;
                end
            end
            skf_pkg::ST_GAIN:
            begin
                cmd.set_gain = 1'b1;
                state_next   = skf_pkg::ST_MULX;
            end
            skf_pkg::ST_MULX:
            begin
                cmd.mul_x  = 1'b1;
                state_next = skf_pkg::ST_MULP;
            end
            skf_pkg::ST_MULP:
            begin
                cmd.mul_p  = 1'b1;
                state_next = skf_pkg::ST_FINISH;
            end
            skf_pkg::ST_FINISH:
            begin
                // hold here while the previous result is still waiting
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.commit = 1'b1;
                    state_next = skf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = skf_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        priority if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_stall)
        begin
            out_valid_next = out_valid_reg;
        end
        else
        begin
            out_valid_next = 1'b0;
        end
    end

    assign in_stall  = (state_reg != skf_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule
`default_nettype wire

// ===== design/skf_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// skf_datapath
// Filter state, noise registers, restoring gain divider, shared multiplier
// and the output register.
// ----------------------------------------------------------------------------
module skf_datapath (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_we,
    input  wire logic [skf_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [skf_pkg::DATA_W-1:0]           cfg_data,
    input  wire skf_pkg::skf_in_t                     in_data,
    input  wire skf_pkg::skf_cmd_t                    cmd,
    output skf_pkg::skf_status_t                      status,
    output skf_pkg::skf_out_t                         out_data
);

    localparam int DW = skf_pkg::DATA_W;
    localparam int GW = skf_pkg::GAIN_W;

    // configuration and filter state
    logic [DW-1:0] q_noise_reg;
    logic [DW-1:0] r_noise_reg;
    logic [DW-1:0] init_est_reg;
    logic [DW-1:0] init_cov_reg;
    logic [DW-1:0] est_reg;
    logic [DW-1:0] est_next;
    logic [DW-1:0] cov_reg;
    logic [GW-1:0] last_gain_reg;

    // per-step working registers
    logic [DW:0]                      diff_reg;
    logic [DW-1:0]                    p_reg;
    logic                             last_reg;
    logic [DW:0]                      den_reg;
    logic [DW:0]                      rem_reg;
    logic [GW-1:0]                    quo_reg;
    logic [skf_pkg::DIV_CNT_W-1:0]    cnt_reg;
    logic [DW-1:0]                    mag_reg;
    logic                             neg_reg;
    logic [GW-1:0]                    k_reg;
    logic [skf_pkg::PROD_W-1:0]       prod_reg;
    skf_pkg::skf_out_t                out_reg;

    logic [DW:0]                      p_sum;
    logic [DW-1:0]                    p_sat;
    logic [DW:0]                      diff_calc;
    logic [DW:0]                      diff_neg;
    logic [DW+1:0]                    rem_shift;
    logic                             rem_ge;
    logic [DW+1:0]                    rem_sub;
    logic [GW-1:0]                    k_calc;
    logic [DW-1:0]                    mul_a;
    logic [skf_pkg::MUL_B_W-1:0]      mul_b;
    logic [skf_pkg::PROD_W-1:0]       mul_y;
    logic [DW-1:0]                    delta;

    // saturating p + q
    assign p_sum     = {1'b0, cov_reg} + {1'b0, q_noise_reg};
    assign p_sat     = p_sum[DW] ? {DW{1'b1}} : p_sum[DW-1:0];
    assign diff_calc = {in_data.measurement[DW-1], in_data.measurement}
                     - {est_reg[DW-1], est_reg};
    assign diff_neg  = ~diff_reg + (DW+1)'(1);

    // one restoring step: quotient bit per cycle, remainder stays below den
    assign rem_shift = {rem_reg, 1'b0};
    assign rem_ge    = (rem_shift >= {1'b0, den_reg});
    assign rem_sub   = rem_shift - {1'b0, den_reg};

    // r == 0: gain is one (clipped) unless p is zero too
    always_comb
    begin
        if (r_noise_reg == '0)
        begin
            k_calc = (p_reg != '0) ? skf_pkg::GAIN_MAX : '0;
        end
        else
        begin
            k_calc = quo_reg;
        end
    end

    // shared multiplier: |z - x| * k, then p * (1 - k)
    always_comb
    begin
        if (cmd.mul_p)
        begin
            mul_a = p_reg;
            mul_b = skf_pkg::GAIN_ONE - {1'b0, k_reg};
        end
        else
        begin
            mul_a = mag_reg;
            mul_b = {1'b0, k_reg};
        end
    end

    assign mul_y    = skf_pkg::PROD_W'(mul_a) * skf_pkg::PROD_W'(mul_b);
    assign delta    = prod_reg[GW +: DW];
    assign est_next = neg_reg ? (est_reg - delta) : (est_reg + delta);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_noise_reg   <= '0;
            r_noise_reg   <= '0;
            init_est_reg  <= '0;
            init_cov_reg  <= '0;
            est_reg       <= '0;
            cov_reg       <= '0;
            last_gain_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    skf_pkg::REG_PROCESS_NOISE:
                    begin
                        q_noise_reg <= cfg_data;
                    end
                    skf_pkg::REG_MEASUREMENT_NOISE:
                    begin
                        r_noise_reg <= cfg_data;
                    end
                    skf_pkg::REG_INITIAL_ESTIMATE:
                    begin
                        init_est_reg <= cfg_data;
                        est_reg      <= cfg_data;
                    end
                    skf_pkg::REG_INITIAL_COVARIANCE:
                    begin
                        init_cov_reg <= cfg_data;
                        cov_reg      <= cfg_data;
                    end
                    default:
                    begin
                    end
                endcase
            end
            else
            begin
                if (cmd.mul_p)
                begin
                    est_reg <= est_next;
                end
                if (cmd.commit)
                begin
                    cov_reg       <= prod_reg[GW +: DW];
                    last_gain_reg <= k_reg;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.prep)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            cnt_reg <= cnt_reg + skf_pkg::DIV_CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            p_reg    <= p_sat;
            diff_reg <= diff_calc;
            last_reg <= in_data.last_sample;
        end
        if (cmd.prep)
        begin
            den_reg <= {1'b0, p_reg} + {1'b0, r_noise_reg};
            rem_reg <= {1'b0, p_reg};
            neg_reg <= diff_reg[DW];
            mag_reg <= diff_reg[DW] ? diff_neg[DW-1:0] : diff_reg[DW-1:0];
        end
        if (cmd.div_step)
        begin
            rem_reg <= rem_ge ? rem_sub[DW:0] : rem_shift[DW:0];
            quo_reg <= {quo_reg[GW-2:0], rem_ge};
        end
        if (cmd.set_gain)
        begin
            k_reg <= k_calc;
        end
        if (cmd.mul_x || cmd.mul_p)
        begin
            prod_reg <= mul_y;
        end
        if (cmd.commit)
        begin
            out_reg.filtered_value <= est_reg;
            out_reg.gain           <= k_reg;
            out_reg.last_result    <= last_reg;
        end
    end

    assign status.div_last = (cnt_reg == skf_pkg::DIV_CNT_W'(GW - 1));
    assign out_data        = out_reg;

endmodule
`default_nettype wire
